// ===== rtl/core/doubly_linked_list_manager_assert.svh =====
// Assertion macros shared by the list manager RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef DOUBLY_LINKED_LIST_MANAGER_ASSERT_SVH
`define DOUBLY_LINKED_LIST_MANAGER_ASSERT_SVH

// Same-cycle implication.
`define DLLM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dllm assertion failed");

// Next-cycle implication.
`define DLLM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dllm assertion failed");

`endif

// ===== rtl/core/dllm_pkg.sv =====
// Shared types and codes for the doubly linked list manager.
// No dependencies.
`timescale 1ns / 1ps

package dllm_pkg;

  localparam int TOTAL_W = 7;

  typedef enum logic [1:0] {
    FUNC_HEAD = 2'd0,
    FUNC_TAIL = 2'd1,
    FUNC_DEL  = 2'd2,
    FUNC_CLR  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // write enables toward the node memories
  typedef struct packed {
    logic val;
    logic nxt;
    logic prv;
  } node_we_t;

endpackage

// ===== rtl/core/dllm_free.sv =====
// Free-slot stack: memory plus top and low-water registers.
// Depends on dllm_pkg.
`timescale 1ns / 1ps

module dllm_free import dllm_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         clear_i,
  input  logic                         pop_i,
  input  logic                         push_i,
  input  logic [$clog2(CAPACITY)-1:0]  push_slot_i,
  output logic [$clog2(CAPACITY)-1:0]  slot_o,
  output logic [$clog2(CAPACITY+1)-1:0] top_o
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [SW-1:0] mem [CAPACITY];
  logic [CW-1:0] top_q, low_q;
  logic [SW-1:0] rd_q, imp_q;
  logic          use_imp_q;
  logic [CW-1:0] top_m1;
  logic [SW-1:0] pop_idx;

  assign top_m1  = top_q - CW'(1);
  assign pop_idx = top_m1[SW-1:0];

  // entries below the low-water mark were never popped since the last clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q     <= CW'(CAPACITY);
      low_q     <= CW'(CAPACITY);
      use_imp_q <= 1'b0;
    end else if (clear_i) begin
      top_q <= CW'(CAPACITY);
      low_q <= CW'(CAPACITY);
    end else if (pop_i) begin
      top_q     <= top_m1;
      use_imp_q <= (top_m1 < low_q);
      if (top_m1 < low_q) begin
        low_q <= top_m1;
      end
    end else if (push_i && (top_q < CW'(CAPACITY))) begin
      top_q <= top_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_i && !clear_i) begin
      rd_q  <= mem[pop_idx];
      imp_q <= SW'(CAPACITY - 1) - pop_idx;
    end
    if (push_i && !pop_i && !clear_i && (top_q < CW'(CAPACITY))) begin
      mem[top_q[SW-1:0]] <= push_slot_i;
    end
  end

  assign slot_o = use_imp_q ? imp_q : rd_q;
  assign top_o  = top_q;

endmodule

// ===== rtl/core/dllm_nodes.sv =====
// Node store: value, next-link and prev-link memories, one read port.
// Depends on dllm_pkg.
`timescale 1ns / 1ps

module dllm_nodes import dllm_pkg::*; #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rd_en_i,
  input  logic [$clog2(CAPACITY)-1:0]   rd_addr_i,
  input  node_we_t                      we_i,
  input  logic [$clog2(CAPACITY)-1:0]   val_addr_i,
  input  logic [VALUE_WIDTH-1:0]        val_data_i,
  input  logic [$clog2(CAPACITY)-1:0]   nxt_addr_i,
  input  logic [$clog2(CAPACITY+1)-1:0] nxt_data_i,
  input  logic [$clog2(CAPACITY)-1:0]   prv_addr_i,
  input  logic [$clog2(CAPACITY+1)-1:0] prv_data_i,
  output logic [VALUE_WIDTH-1:0]        rd_val_o,
  output logic [$clog2(CAPACITY+1)-1:0] rd_nxt_o,
  output logic [$clog2(CAPACITY+1)-1:0] rd_prv_o
);

  localparam int IW = $clog2(CAPACITY + 1);

  logic [VALUE_WIDTH-1:0] val_mem [CAPACITY];
  logic [IW-1:0]          nxt_mem [CAPACITY];
  logic [IW-1:0]          prv_mem [CAPACITY];

  always_ff @(posedge clk_i) begin
    if (we_i.val) begin
      val_mem[val_addr_i] <= val_data_i;
    end
    if (we_i.nxt) begin
      nxt_mem[nxt_addr_i] <= nxt_data_i;
    end
    if (we_i.prv) begin
      prv_mem[prv_addr_i] <= prv_data_i;
    end
    if (rd_en_i) begin
      rd_val_o <= val_mem[rd_addr_i];
      rd_nxt_o <= nxt_mem[rd_addr_i];
      rd_prv_o <= prv_mem[rd_addr_i];
    end
  end

endmodule

// ===== rtl/core/doubly_linked_list_manager.sv =====
// Doubly linked list manager with a free-slot stack; one item at a time.
// Clear goes straight to the response; insert passes S_POP and S_LINK2; delete walks
// up to CAPACITY nodes, one read of the node memory per cycle.
// Throughput: next item accepted once the previous result is handed to the output reg.
// Reset (async, active low) empties the list directly; no clearing pass.
`timescale 1ns / 1ps

module doubly_linked_list_manager import dllm_pkg::*; #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           func_i,
  input  logic [31:0]          value_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           status_o,
  output logic [TOTAL_W-1:0]   entry_total_o
);

`include "doubly_linked_list_manager_assert.svh"

  localparam int SW = $clog2(CAPACITY);
  localparam int IW = $clog2(CAPACITY + 1);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] SENT = IW'(CAPACITY);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_POP   = 3'd1; // free slot read in flight
  localparam logic [2:0] S_LINK2 = 3'd2; // neighbor link write
  localparam logic [2:0] S_WALK  = 3'd3; // delete search, one node a cycle
  localparam logic [2:0] S_RESP  = 3'd4; // hand result to output reg

  // control state
  logic [2:0]    state_q, state_d;
  logic [IW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic          out_valid_q;
  // working registers
  logic [VALUE_WIDTH-1:0] key_q, key_d;
  logic                   at_head_q, at_head_d;
  logic [SW-1:0]          slot_q, slot_d;
  logic [IW-1:0]          nb_q, nb_d;
  logic [SW-1:0]          cur_q, cur_d;
  logic [SW-1:0]          steps_q, steps_d;
  status_e                stat_q, stat_d;
  status_e                out_status_q;
  logic [TOTAL_W-1:0]     out_total_q;

  // free stack
  logic          fs_clear, fs_pop, fs_push;
  logic [SW-1:0] fs_slot;
  logic [CW-1:0] fs_top;

  // node store
  logic                   nd_rd_en;
  logic [SW-1:0]          nd_rd_addr;
  node_we_t               nd_we;
  logic [SW-1:0]          nd_val_addr, nd_nxt_addr, nd_prv_addr;
  logic [IW-1:0]          nd_nxt_data, nd_prv_data;
  logic [VALUE_WIDTH-1:0] nd_val;
  logic [IW-1:0]          nd_nxt, nd_prv;

  logic in_fire, load_out;

  dllm_free #(.CAPACITY(CAPACITY)) u_free (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (fs_clear),
    .pop_i       (fs_pop),
    .push_i      (fs_push),
    .push_slot_i (cur_q),
    .slot_o      (fs_slot),
    .top_o       (fs_top)
  );

  dllm_nodes #(.CAPACITY(CAPACITY), .VALUE_WIDTH(VALUE_WIDTH)) u_nodes (
    .clk_i      (clk_i),
    .rd_en_i    (nd_rd_en),
    .rd_addr_i  (nd_rd_addr),
    .we_i       (nd_we),
    .val_addr_i (nd_val_addr),
    .val_data_i (key_q),
    .nxt_addr_i (nd_nxt_addr),
    .nxt_data_i (nd_nxt_data),
    .prv_addr_i (nd_prv_addr),
    .prv_data_i (nd_prv_data),
    .rd_val_o   (nd_val),
    .rd_nxt_o   (nd_nxt),
    .rd_prv_o   (nd_prv)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign load_out   = (state_q == S_RESP) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    key_d     = key_q;
    at_head_d = at_head_q;
    slot_d    = slot_q;
    nb_d      = nb_q;
    cur_d     = cur_q;
    steps_d   = steps_q;
    stat_d    = stat_q;

    fs_clear    = 1'b0;
    fs_pop      = 1'b0;
    fs_push     = 1'b0;
    nd_rd_en    = 1'b0;
    nd_rd_addr  = head_q[SW-1:0];
    nd_we       = '0;
    nd_val_addr = fs_slot;
    nd_nxt_addr = fs_slot;
    nd_prv_addr = fs_slot;
    nd_nxt_data = SENT;
    nd_prv_data = SENT;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          key_d = VALUE_WIDTH'(value_i);
          case (func_e'(func_i))
            FUNC_HEAD, FUNC_TAIL: begin
              at_head_d = (func_e'(func_i) == FUNC_HEAD);
              if (fs_top == '0) begin
                stat_d  = ST_FULL;
                state_d = S_RESP;
              end else begin
                fs_pop  = 1'b1;
                state_d = S_POP;
              end
            end
            FUNC_DEL: begin
              if (head_q == SENT) begin
                stat_d  = ST_NOT_FOUND;
                state_d = S_RESP;
              end else begin
                nd_rd_en   = 1'b1;
                nd_rd_addr = head_q[SW-1:0];
                cur_d      = head_q[SW-1:0];
                steps_d    = '0;
                state_d    = S_WALK;
              end
            end
            default: begin
              fs_clear = 1'b1;
              head_d   = SENT;
              tail_d   = SENT;
              count_d  = '0;
              stat_d   = ST_DONE;
              state_d  = S_RESP;
            end
          endcase
        end
      end

      S_POP: begin
        // new node: value and its own two links
        slot_d    = fs_slot;
        nd_we.val = 1'b1;
        nd_we.nxt = 1'b1;
        nd_we.prv = 1'b1;
        if (at_head_q) begin
          nd_nxt_data = head_q;
          nd_prv_data = SENT;
          nb_d        = head_q;
          if (head_q == SENT) begin
            tail_d = IW'(fs_slot);
          end
          head_d = IW'(fs_slot);
        end else begin
          nd_nxt_data = SENT;
          nd_prv_data = tail_q;
          nb_d        = tail_q;
          if (tail_q == SENT) begin
            head_d = IW'(fs_slot);
          end
          tail_d = IW'(fs_slot);
        end
        state_d = S_LINK2;
      end

      S_LINK2: begin
        // old head's prev or old tail's next now points at the new node
        if (nb_q != SENT) begin
          if (at_head_q) begin
            nd_we.prv   = 1'b1;
            nd_prv_addr = nb_q[SW-1:0];
            nd_prv_data = IW'(slot_q);
          end else begin
            nd_we.nxt   = 1'b1;
            nd_nxt_addr = nb_q[SW-1:0];
            nd_nxt_data = IW'(slot_q);
          end
        end
        count_d = count_q + CW'(1);
        stat_d  = ST_DONE;
        state_d = S_RESP;
      end

      S_WALK: begin
        if (nd_val == key_q) begin
          // unlink: prev of after, next of before
          if (nd_nxt == SENT) begin
            tail_d = nd_prv;
          end else begin
            nd_we.prv   = 1'b1;
            nd_prv_addr = nd_nxt[SW-1:0];
            nd_prv_data = nd_prv;
          end
          if (nd_prv == SENT) begin
            head_d = nd_nxt;
          end else begin
            nd_we.nxt   = 1'b1;
            nd_nxt_addr = nd_prv[SW-1:0];
            nd_nxt_data = nd_nxt;
          end
          fs_push = 1'b1;
          if (count_q != '0) begin
            count_d = count_q - CW'(1);
          end
          stat_d  = ST_DONE;
          state_d = S_RESP;
        end else if ((steps_q == SW'(CAPACITY - 1)) || (nd_nxt == SENT)) begin
          stat_d  = ST_NOT_FOUND;
          state_d = S_RESP;
        end else begin
          nd_rd_en   = 1'b1;
          nd_rd_addr = nd_nxt[SW-1:0];
          cur_d      = nd_nxt[SW-1:0];
          steps_d    = steps_q + SW'(1);
        end
      end

      S_RESP: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= SENT;
      tail_q      <= SENT;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    at_head_q <= at_head_d;
    slot_q    <= slot_d;
    nb_q      <= nb_d;
    cur_q     <= cur_d;
    steps_q   <= steps_d;
    stat_q    <= stat_d;
    if (load_out) begin
      out_status_q <= stat_q;
      out_total_q  <= TOTAL_W'(count_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign entry_total_o = out_total_q;

  // every slot is either linked or on the free stack between items
  `DLLM_ASSERT_IMP(a_slot_cons, (state_q == S_IDLE), ((CW+1)'(count_q) + (CW+1)'(fs_top) == (CW+1)'(CAPACITY)))
  // head and tail reach the sentinel together
  `DLLM_ASSERT_IMP(a_ends_agree, 1'b1, ((head_q == SENT) == (tail_q == SENT)))
  // empty list exactly when the count is zero
  `DLLM_ASSERT_IMP(a_empty_cnt, (state_q == S_IDLE), ((head_q == SENT) == (count_q == '0)))
  // refused insert only with every slot in use
  `DLLM_ASSERT_NXT(a_full_ok, (load_out && (stat_q == ST_FULL)), (count_q == CW'(CAPACITY)))

endmodule

// ===== tb/doubly_linked_list_manager_test.sv =====
// Testbench for doubly_linked_list_manager: random and directed list operations,
// checked beat by beat against an in-bench model of the bounded circular list.
// Depends on dllm_pkg and the list manager RTL.
`timescale 1ns / 1ps

// Tracks the list contents and queues the status and count each operation should return.
class list_scoreboard;
  localparam int CAP = 64;
  localparam int SENT = CAP;

  logic [31:0] slot_val [CAP];
  int unsigned nxt [CAP+1];
  int unsigned prv [CAP+1];
  int unsigned free_stack [CAP];
  int unsigned free_cnt;
  int unsigned live_cnt;
  dllm_pkg::status_e status_q[$];
  int unsigned total_q[$];
  int errors;

  function new();
    errors = 0;
    empty_list();
  endfunction

  function void empty_list();
    nxt[SENT] = SENT;
    prv[SENT] = SENT;
    for (int i = 0; i < CAP; i++) begin
      nxt[i] = SENT;
      prv[i] = SENT;
      free_stack[i] = CAP - 1 - i;
    end
    free_cnt = CAP;
    live_cnt = 0;
  endfunction

  function int unsigned pending();
    return status_q.size();
  endfunction

  function int unsigned count();
    return live_cnt;
  endfunction

  // Apply one accepted operation and queue its expected result.
  function void note_op(dllm_pkg::func_e op, logic [31:0] v);
    dllm_pkg::status_e st;
    int unsigned slot, cur, a, b;
    bit hit;
    st = dllm_pkg::ST_DONE;
    case (op)
      dllm_pkg::FUNC_HEAD, dllm_pkg::FUNC_TAIL: begin
        if (free_cnt == 0) begin
          st = dllm_pkg::ST_FULL;
        end else begin
          free_cnt--;
          slot = free_stack[free_cnt];
          slot_val[slot] = v;
          if (op == dllm_pkg::FUNC_HEAD) begin
            b = SENT; a = nxt[SENT];
          end else begin
            b = prv[SENT]; a = SENT;
          end
          prv[a] = slot; nxt[slot] = a; prv[slot] = b; nxt[b] = slot;
          live_cnt++;
        end
      end
      dllm_pkg::FUNC_DEL: begin
        cur = nxt[SENT];
        hit = 0;
        for (int s = 0; s < CAP && cur != SENT && !hit; s++) begin
          if (slot_val[cur] == v) begin
            hit = 1;
            b = prv[cur]; a = nxt[cur];
            prv[a] = b; nxt[b] = a;
            free_stack[free_cnt] = cur;
            free_cnt++;
            live_cnt--;
          end else begin
            cur = nxt[cur];
          end
        end
        if (!hit) st = dllm_pkg::ST_NOT_FOUND;
      end
      default: empty_list();
    endcase
    status_q.push_back(st);
    total_q.push_back(live_cnt);
  endfunction

  // Compare one result beat with the oldest expectation.
  function void check_result(logic [1:0] st, logic [6:0] tot);
    if (status_q.size() == 0) begin
      $error("result beat with nothing expected: status %0d total %0d", st, tot);
      errors++;
      return;
    end
    if (st !== status_q[0]) begin
      $error("status: expected %0d, got %0d", status_q[0], st);
      errors++;
    end
    if (tot !== total_q[0][6:0]) begin
      $error("entry_total: expected %0d, got %0d", total_q[0], tot);
      errors++;
    end
    void'(status_q.pop_front());
    void'(total_q.pop_front());
  endfunction
endclass

module doubly_linked_list_manager_test;
  import dllm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] func_i = '0;
  logic [31:0] value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] status_o;
  logic [TOTAL_W-1:0] entry_total_o;

  // idle percentages per side; hold_off forces a long output stall
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off = 0;
  int unsigned cycles = 0;

  // small value pool so deletes find matches often
  logic [31:0] pool [8];

  list_scoreboard board;

  doubly_linked_list_manager DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i, .value_i,
    .out_valid_o, .out_ready_i, .status_o, .entry_total_o
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Cycle counter and timeout.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: ready toggles at falling edges; results sampled at rising edges.
  always @(negedge clk_i) begin
    if (!rst_ni || hold_off) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_result(status_o, entry_total_o);
    end
  end

  // Offer one beat and hold it until accepted; the model is updated at acceptance.
  // Valid drops at the falling edge after acceptance and rises again no earlier
  // than the next falling edge.
  task automatic send_op(func_e op, logic [31:0] v);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_valid_i <= 1'b1;
    func_i <= op;
    value_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_op(op, v);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (board.pending() != 0) @(negedge clk_i);
  endtask

  // Mostly inserts and deletes of pool values, some clears and wide random values.
  task automatic send_random(int n);
    int r;
    logic [31:0] v;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      v = ($urandom_range(3) == 0) ? $urandom() : pool[$urandom_range(7)];
      if (r < 2) send_op(FUNC_CLR, v);
      else if (r < 30) send_op(FUNC_HEAD, v);
      else if (r < 60) send_op(FUNC_TAIL, v);
      else send_op(FUNC_DEL, v);
    end
  endtask

  // Long output stall in its own process while inputs keep coming.
  task automatic stall_output();
    fork
      begin
        hold_off = 1;
        repeat (600) @(negedge clk_i);
        hold_off = 0;
      end
      send_random(12);
    join
  endtask

  initial begin
    board = new();
    for (int i = 0; i < 8; i++) pool[i] = $urandom();
    pool[0] = 32'h0;
    pool[1] = 32'hFFFF_FFFF;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty-list delete and clear, extremes, duplicates, fill past capacity.
    send_op(FUNC_DEL, 32'h0);
    send_op(FUNC_CLR, 32'h0);
    send_op(FUNC_HEAD, 32'h0);
    send_op(FUNC_TAIL, 32'hFFFF_FFFF);
    send_op(FUNC_HEAD, 32'hFFFF_FFFF);
    send_op(FUNC_DEL, 32'hFFFF_FFFF);   // first match only
    send_op(FUNC_DEL, 32'h1234_5678);   // not found
    send_op(FUNC_DEL, 32'hFFFF_FFFF);
    send_op(FUNC_DEL, 32'h0);
    send_op(FUNC_TAIL, 32'hA5A5_5A5A);
    send_op(FUNC_CLR, 32'hFFFF_FFFF);
    while (board.count() < 64) send_op(FUNC_TAIL, $urandom());
    send_op(FUNC_HEAD, 32'h5A5A_A5A5);  // full
    send_op(FUNC_TAIL, 32'h5A5A_A5A5);  // full
    send_op(FUNC_DEL, 32'h7777_7777);   // full-length walk, no match
    send_op(FUNC_CLR, 32'h0);
    drain();

    send_idle_pct = 35; recv_idle_pct = 74;
    send_random(100);
    stall_output();
    drain();                            // sender waits for all results
    send_idle_pct = 74; recv_idle_pct = 35;
    send_random(100);
    send_idle_pct = 0; recv_idle_pct = 0;
    send_random(100);

    drain();
    repeat (80) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/dllm_pkg.sv
rtl/core/dllm_free.sv
rtl/core/dllm_nodes.sv
rtl/core/doubly_linked_list_manager.sv
tb/doubly_linked_list_manager_test.sv
